// ===== hdl/rhtm_pkg.sv =====
// shared types and constants for the reading history tolerance match block
package rhtm_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int COORD_BITS_DEF = 8;

	localparam int LEVEL_W   = 24;
	localparam int STAMP_W   = 32;
	localparam int HTOL_W    = 23;
	localparam int TTOL_W    = 16;
	localparam int COUNT_W   = 32;
	localparam int CFG_W     = 23;
	localparam int CFG_IDX_W = 1;

	localparam logic [HTOL_W-1:0] HTOL_RESET = HTOL_W'(100000);
	localparam logic [TTOL_W-1:0] TTOL_RESET = TTOL_W'(60);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_TOL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_TOL   = 1'b1;

	// transaction kinds
	localparam logic KIND_STORE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic        [STAMP_W-1:0] stamp;
	} reading_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// ===== hdl/rhtm_tol_cmp.sv =====
// tolerance compare unit: absolute height and time differences against limits
module rhtm_tol_cmp (
	input  rhtm_pkg::reading_t              qry,
	input  rhtm_pkg::reading_t              ent,
	input  logic [rhtm_pkg::HTOL_W-1:0]     height_tol,
	input  logic [rhtm_pkg::TTOL_W-1:0]     time_tol,
	output logic                            in_tol
);

	localparam int DH_W = rhtm_pkg::LEVEL_W + 1;
	localparam int DT_W = rhtm_pkg::STAMP_W + 1;

	logic [DH_W-1:0] dh_raw;
	logic [DH_W-1:0] dh_abs;
	logic [DT_W-1:0] dt_raw;
	logic [DT_W-1:0] dt_abs;

	always_comb begin
		dh_raw = {qry.level[rhtm_pkg::LEVEL_W-1], qry.level}
			- {ent.level[rhtm_pkg::LEVEL_W-1], ent.level};
		dh_abs = dh_raw[DH_W-1] ? (~dh_raw + 1'b1) : dh_raw;
		dt_raw = {1'b0, qry.stamp} - {1'b0, ent.stamp};
		dt_abs = dt_raw[DT_W-1] ? (~dt_raw + 1'b1) : dt_raw;
		in_tol = (dh_abs <= DH_W'(height_tol)) && (dt_abs <= DT_W'(time_tol));
	end

endmodule

// ===== hdl/reading_history_tolerance_match_top.sv =====
// top level: reading history ring with newest-first tolerance match scan
//
// A store transaction (kind 0) is taken at once: the reading is written
// to the ring slot after the newest one, overwriting the oldest when the ring
// is full, and busy stays low. A query transaction (kind 1) raises busy and
// scans the stored readings from newest to oldest, one entry per cycle through
// the single read port of the history memory and one shared tolerance compare
// unit. A match or the oldest entry ends the scan; done is registered from
// the finish state that follows, which an empty ring enters directly. Busy
// falls in the done cycle, so the next transaction can be taken there. The
// result is valid with done and holds until the next transaction is taken;
// the receiver cannot stall it. The user must write tolerances through
// cfg_we/cfg_addr/cfg_wdata while the block is idle; the block does not
// enforce this. After reset the history is empty; no memory clear is needed.
module reading_history_tolerance_match_top #(
	parameter int CAPACITY   = rhtm_pkg::CAPACITY_DEF,
	parameter int COORD_BITS = rhtm_pkg::COORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration write port
	input  logic                                    cfg_we,
	input  logic [rhtm_pkg::CFG_IDX_W-1:0]          cfg_addr,
	input  logic [rhtm_pkg::CFG_W-1:0]              cfg_wdata,
	// command side
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    kind,
	input  logic [COORD_BITS-1:0]                   pos_x,
	input  logic [COORD_BITS-1:0]                   pos_y,
	input  logic signed [rhtm_pkg::LEVEL_W-1:0]     level_mm,
	input  logic [rhtm_pkg::STAMP_W-1:0]            stamp,
	// result side
	output logic                                    done,
	output logic                                    alert_true,
	output logic                                    found_position,
	output logic signed [rhtm_pkg::LEVEL_W-1:0]     match_level_mm,
	output logic [rhtm_pkg::STAMP_W-1:0]            match_stamp,
	output logic [rhtm_pkg::COUNT_W-1:0]            true_count,
	output logic [rhtm_pkg::COUNT_W-1:0]            false_count
);

	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int KEY_W  = 2 * COORD_BITS;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0]  FILL_FULL = CNT_W'(CAPACITY);

	// history memory, one row per reading
	logic [KEY_W-1:0]   key_mem [CAPACITY];
	rhtm_pkg::reading_t rd_mem  [CAPACITY];

	rhtm_pkg::state_t state_q, state_d;

	// ring bookkeeping and counters
	logic [SLOT_W-1:0]             newest_q;
	logic [CNT_W-1:0]              fill_q;
	logic [rhtm_pkg::COUNT_W-1:0]  true_q;
	logic [rhtm_pkg::COUNT_W-1:0]  false_q;
	logic [rhtm_pkg::HTOL_W-1:0]   htol_q;
	logic [rhtm_pkg::TTOL_W-1:0]   ttol_q;

	// query being worked on
	logic [KEY_W-1:0]    qkey_q;
	rhtm_pkg::reading_t  qrd_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    cnt_q;

	// registered memory read
	logic                rvalid_s1;
	logic                last_s1;
	logic [KEY_W-1:0]    rkey_s1;
	rhtm_pkg::reading_t  rrd_s1;

	// result being built
	logic                hit_q;
	logic                found_q;
	rhtm_pkg::reading_t  mrd_q;
	logic                done_q;

	logic                accept;
	logic                mem_we;
	logic                issue;
	logic                key_eq;
	logic                in_tol;
	logic                hit_now;
	logic                scan_end;
	logic [SLOT_W-1:0]   wr_slot;
	logic [SLOT_W-1:0]   slot_prev;
	logic [KEY_W-1:0]    key_in;

	assign busy    = (state_q != rhtm_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign mem_we  = accept && (kind == rhtm_pkg::KIND_STORE);
	assign key_in  = {pos_x, pos_y};
	// next ring slot after the newest, and walking back toward the oldest
	assign wr_slot   = (newest_q == SLOT_LAST) ? '0 : SLOT_W'(newest_q + 1'b1);
	assign slot_prev = (slot_q == '0) ? SLOT_LAST : SLOT_W'(slot_q - 1'b1);

	// shared compare on the entry just read
	rhtm_tol_cmp u_cmp (
		.qry        (qrd_q),
		.ent        (rrd_s1),
		.height_tol (htol_q),
		.time_tol   (ttol_q),
		.in_tol     (in_tol)
	);

	assign key_eq   = (rkey_s1 == qkey_q);
	assign hit_now  = rvalid_s1 && key_eq && in_tol;
	// scan stops at the first match or after the oldest stored entry
	assign scan_end = rvalid_s1 && (hit_now || last_s1);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rhtm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and read issue
	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		unique case (state_q)
			rhtm_pkg::ST_IDLE: begin
				if (accept && (kind == rhtm_pkg::KIND_QUERY)) begin
					// empty ring goes straight to the result
					state_d = (fill_q == '0) ? rhtm_pkg::ST_FINISH : rhtm_pkg::ST_SCAN;
				end
			end
			rhtm_pkg::ST_SCAN: begin
				issue = !scan_end && (cnt_q < fill_q);
				if (scan_end) begin
					state_d = rhtm_pkg::ST_FINISH;
				end
			end
			rhtm_pkg::ST_FINISH: begin
				state_d = rhtm_pkg::ST_IDLE;
			end
			default: begin
				state_d = rhtm_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q  <= SLOT_LAST;
			fill_q    <= '0;
			true_q    <= '0;
			false_q   <= '0;
			htol_q    <= rhtm_pkg::HTOL_RESET;
			ttol_q    <= rhtm_pkg::TTOL_RESET;
			cnt_q     <= '0;
			rvalid_s1 <= 1'b0;
			last_s1   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					rhtm_pkg::REG_HEIGHT_TOL: htol_q <= cfg_wdata[rhtm_pkg::HTOL_W-1:0];
					rhtm_pkg::REG_TIME_TOL:   ttol_q <= cfg_wdata[rhtm_pkg::TTOL_W-1:0];
				endcase
			end
			if (mem_we) begin
				newest_q <= wr_slot;
				if (fill_q != FILL_FULL) begin
					fill_q <= CNT_W'(fill_q + 1'b1);
				end
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end
			rvalid_s1 <= issue;
			last_s1   <= issue && (CNT_W'(cnt_q + 1'b1) == fill_q);
			// saturating alert totals, updated once per query
			if (state_q == rhtm_pkg::ST_FINISH) begin
				if (hit_q) begin
					if (true_q != '1) begin
						true_q <= true_q + 1'b1;
					end
				end else begin
					if (false_q != '1) begin
						false_q <= false_q + 1'b1;
					end
				end
			end
			done_q <= (state_q == rhtm_pkg::ST_FINISH);
		end
	end

	// history memory write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[wr_slot] <= key_in;
			rd_mem[wr_slot]  <= '{level: level_mm, stamp: stamp};
		end
		if (issue) begin
			rkey_s1 <= key_mem[slot_q];
			rrd_s1  <= rd_mem[slot_q];
		end
	end

	// query capture and result build-up
	always_ff @(posedge clk) begin
		if (accept) begin
			qkey_q  <= key_in;
			qrd_q   <= '{level: level_mm, stamp: stamp};
			slot_q  <= newest_q;
			hit_q   <= 1'b0;
			found_q <= 1'b0;
			mrd_q   <= '0;
		end else if (state_q == rhtm_pkg::ST_SCAN) begin
			if (issue) begin
				slot_q <= slot_prev;
			end
			if (rvalid_s1 && key_eq) begin
				if (in_tol) begin
					hit_q   <= 1'b1;
					found_q <= 1'b1;
					mrd_q   <= rrd_s1;
				end else if (!found_q) begin
					// newest same-position entry is kept as the fallback
					found_q <= 1'b1;
					mrd_q   <= rrd_s1;
				end
			end
		end
	end

	assign done           = done_q;
	assign alert_true     = hit_q;
	assign found_position = found_q;
	assign match_level_mm = mrd_q.level;
	assign match_stamp    = mrd_q.stamp;
	assign true_count     = true_q;
	assign false_count    = false_q;

endmodule

// ===== hdl/rhtm_checker.sv =====
// port level checks for the reading history tolerance match top, with bind
module rhtm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 kind,
	input logic                                 done,
	input logic                                 alert_true,
	input logic                                 found_position,
	input logic signed [rhtm_pkg::LEVEL_W-1:0]  match_level_mm,
	input logic [rhtm_pkg::STAMP_W-1:0]         match_stamp,
	input logic [rhtm_pkg::COUNT_W-1:0]         true_count,
	input logic [rhtm_pkg::COUNT_W-1:0]         false_count
);

	// result cycle frees the command side
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy high in result cycle");

	// a true alert always comes from a same-position entry
	a_true_has_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && alert_true) |-> found_position)
		else $error("true alert without position match");

	// no position match reports zero height and time
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found_position) |-> (match_level_mm == '0 && match_stamp == '0))
		else $error("miss result carries nonzero reading");

	// totals move only with a result
	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> ($stable(true_count) && $stable(false_count)))
		else $error("alert totals changed without a result");

	// a query transaction keeps the block busy in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == rhtm_pkg::KIND_QUERY) |=> busy)
		else $error("query taken but block not busy");

endmodule

bind reading_history_tolerance_match_top rhtm_checker u_rhtm_checker (.*);
